// ===== rtl/core/ewpf_pkg.sv =====
// package for the exp weighted pair feature accumulator
// fixed point constants, widths, mode codes, the sequencer state type and the ring control struct; no dependencies
package ewpf_pkg;

  localparam int DistW  = 16;
  localparam int CoefW  = 16;
  localparam int AccW   = 48;
  localparam int TermW  = 35;
  localparam int ExpW   = 28;

  localparam logic signed [31:0] Log2eQ30 = 32'sd1549082005;
  localparam logic [26:0] PolyC3 = 27'd83908186;
  localparam logic [27:0] PolyC2 = 28'd242852024;
  localparam logic [29:0] PolyC1 = 30'd746848487;
  localparam logic [ExpW-1:0] ExpMax = '1;

  localparam logic [1:0] ModeLoad     = 2'd0;
  localparam logic [1:0] ModeAdd      = 2'd1;
  localparam logic [1:0] ModeAddEmit  = 2'd2;
  localparam logic [1:0] ModeEmit     = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StDrain,
    StEmit
  } seq_state_e;

  typedef struct packed {
    logic shift;
    logic add;
    logic clr;
  } ring_ctrl_t;

endpackage

// ===== rtl/core/ewpf_cell.sv =====
// one accumulator cell of the feature ring
// on a shift takes its neighbor's sum, optionally adds a term with saturation, or clears to zero; uses ewpf_pkg
module ewpf_cell import ewpf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ring_ctrl_t             ctrl_i,
  input  logic signed [AccW-1:0] prev_i,
  input  logic signed [TermW-1:0] term_i,
  output logic signed [AccW-1:0] sum_o
);

  logic signed [AccW-1:0] sum_q, sum_d;
  logic signed [AccW:0]   wide;

  always_comb begin
    wide = {prev_i[AccW-1], prev_i} + {{(AccW+1-TermW){term_i[TermW-1]}}, term_i};
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (!ctrl_i.add) begin
      sum_d = prev_i;
    end else if (wide[AccW] != wide[AccW-1]) begin
      sum_d = wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sum_d = wide[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.shift) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/core/ewpf_exp_unit.sv =====
// pipelined term unit: d * exp(alpha * d) * weight, or zero when zero_i is set, eight register stages
// base-2 range reduction and a cubic polynomial; uses ewpf_pkg
module ewpf_exp_unit import ewpf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic                    zero_i,
  input  logic signed [DistW-1:0] dist_i,
  input  logic signed [CoefW-1:0] alpha_i,
  input  logic signed [CoefW-1:0] weight_i,
  output logic                    vld_o,
  output logic signed [TermW-1:0] term_o
);

  logic [7:0] v_q;
  logic [7:0] z_q;
  logic signed [CoefW-1:0] w_q [7];

  logic signed [31:0] x_q;
  logic signed [63:0] xl;
  logic signed [26:0] t_q;
  logic [29:0] g3_q, g4_q;
  logic signed [6:0] k3_q, k4_q, k5_q;
  logic [56:0] m3;
  logic [28:0] p3_q;
  logic [58:0] m4;
  logic [30:0] p4_q;
  logic [60:0] m5;
  logic [31:0] p5_q;
  logic signed [7:0] sh;
  logic [31:0] shifted;
  logic [ExpW-1:0] e_d, e_q;
  logic signed [44:0] de_q;
  logic signed [60:0] dew;
  logic signed [TermW-1:0] term_q;

  assign xl = 64'(x_q) * 64'(Log2eQ30);
  assign m3 = 57'(PolyC3) * 57'({t_q[19:0], 10'b0});
  assign m4 = 59'(p3_q) * 59'(g3_q);
  assign m5 = 61'(p4_q) * 61'(g4_q);
  assign sh = 8'sd14 - {k5_q[6], k5_q};
  assign shifted = p5_q >> sh[5:0];
  assign dew = 61'(de_q) * 61'(w_q[6]);

  always_comb begin
    if (k5_q >= 7'sd12) begin
      e_d = ExpMax;
    end else if (sh >= 8'sd40) begin
      e_d = '0;
    end else if (shifted > 32'(ExpMax)) begin
      e_d = ExpMax;
    end else begin
      e_d = shifted[ExpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    z_q  <= {z_q[6:0], zero_i};
    w_q[0] <= weight_i;
    for (int j = 1; j < 7; j++) begin
      w_q[j] <= w_q[j-1];
    end
    x_q  <= 32'(alpha_i) * 32'(dist_i);
    t_q  <= xl[62:36];
    g3_q <= {t_q[19:0], 10'b0};
    k3_q <= t_q[26:20];
    p3_q <= 29'(PolyC2) + 29'(m3 >> 30);
    g4_q <= g3_q;
    k4_q <= k3_q;
    p4_q <= 31'(PolyC1) + 31'(m4 >> 30);
    k5_q <= k4_q;
    p5_q <= 32'h4000_0000 + 32'(m5 >> 30);
    e_q  <= e_d;
    de_q <= 45'(dist_i) * 45'($signed({1'b0, e_q}));
    term_q <= z_q[6] ? '0 : dew[60:26];
  end

  assign vld_o  = v_q[7];
  assign term_o = term_q;

endmodule

// ===== rtl/core/exp_weighted_pair_feature_accumulator.sv =====
// top level: coefficient tables, sequencer, term unit and accumulator ring
// depends on ewpf_pkg, ewpf_exp_unit and ewpf_cell
//
// A neighbor transaction issues NUM_ALPHA table reads, one per cycle, into the
// shared term unit, then drains that pipeline into the accumulator ring; the
// ring rotates once per term so every accumulator sits at the adder in turn.
// An emit then rotates the ring through every cell, one result per cycle while
// the output is taken. Input is accepted only between transactions.
module exp_weighted_pair_feature_accumulator import ewpf_pkg::*; #(
  parameter int NUM_ALPHA = 16,
  parameter int NUM_TYPES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [4:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic signed [DistW-1:0] distance_i,
  input  logic [2:0]              neighbor_type_i,
  input  logic [3:0]              coef_index_i,
  input  logic signed [CoefW-1:0] alpha_coef_i,
  input  logic signed [CoefW-1:0] weight_coef_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              feature_index_o,
  output logic signed [AccW-1:0]  feature_value_o,
  output logic                    last_feature_o
);

  localparam int TblN = NUM_TYPES * NUM_ALPHA;
  localparam int AW = (TblN > 1) ? $clog2(TblN) : 1;
  localparam int CW = $clog2(NUM_ALPHA + 1);

  logic [4:0] num_alpha_q;
  logic [4:0] n_act;
  seq_state_e state_q, state_d;
  logic [CW-1:0] iss_q, iss_d, cnt_q, cnt_d;
  logic emit_q, emit_d;
  logic [2:0] type_q;
  logic signed [DistW-1:0] dist_q;
  logic in_acc, type_ok, load_ok;

  logic signed [CoefW-1:0] alpha_mem [TblN];
  logic signed [CoefW-1:0] weight_mem [TblN];
  logic signed [CoefW-1:0] rd_a_q, rd_w_q;
  logic [AW-1:0] wr_addr, rd_addr;
  logic iss_en, iss_v_q, iss_z_q;

  logic term_vld;
  logic signed [TermW-1:0] term;
  ring_ctrl_t ring_ctrl, pass_ctrl;
  logic signed [AccW-1:0] sums [NUM_ALPHA];

  logic emit_go, emit_out;
  logic out_valid_q;
  logic [3:0] out_idx_q;
  logic signed [AccW-1:0] out_val_q;
  logic out_last_q;

  always_comb begin
    int n;
    n = (num_alpha_q == 5'd0) ? 1 : int'(num_alpha_q);
    if (n > NUM_ALPHA) n = NUM_ALPHA;
    if (n > 16) n = 16;
    n_act = 5'(n);
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc = in_valid_i && in_ready_o;
  assign type_ok = int'(neighbor_type_i) < NUM_TYPES;
  assign load_ok = type_ok && (int'(coef_index_i) < NUM_ALPHA);
  assign wr_addr = AW'(neighbor_type_i) * AW'(NUM_ALPHA) + AW'(coef_index_i);
  assign rd_addr = AW'(type_q) * AW'(NUM_ALPHA) + AW'(iss_q);
  assign iss_en = (state_q == StIssue);

  assign emit_out = int'(cnt_q) < int'(n_act);
  assign emit_go = (state_q == StEmit) && (!emit_out || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_alpha_q <= 5'd16;
    end else if (cfg_we_i) begin
      num_alpha_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iss_q   <= '0;
      cnt_q   <= '0;
      emit_q  <= 1'b0;
      iss_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      iss_v_q <= iss_en;
    end
  end

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    case (state_q)
      StIdle: begin
        iss_d = '0;
        cnt_d = '0;
        if (in_acc) begin
          emit_d = (mode_i == ModeAddEmit);
          if ((mode_i == ModeAdd || mode_i == ModeAddEmit) && type_ok) begin
            state_d = StIssue;
          end else if (mode_i == ModeAddEmit || mode_i == ModeEmit) begin
            state_d = StEmit;
          end
        end
      end
      StIssue: begin
        iss_d = iss_q + 1'b1;
        if (iss_q == CW'(NUM_ALPHA - 1)) begin
          state_d = StDrain;
        end
        if (term_vld) cnt_d = cnt_q + 1'b1;
      end
      StDrain: begin
        if (term_vld) cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_ALPHA)) begin
          cnt_d = '0;
          state_d = emit_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (emit_go) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(NUM_ALPHA - 1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      type_q <= neighbor_type_i;
      dist_q <= distance_i;
    end
    if (in_acc && mode_i == ModeLoad && load_ok) begin
      alpha_mem[wr_addr]  <= alpha_coef_i;
      weight_mem[wr_addr] <= weight_coef_i;
    end
    if (iss_en) begin
      rd_a_q <= alpha_mem[rd_addr];
      rd_w_q <= weight_mem[rd_addr];
    end
    iss_z_q <= !(int'(iss_q) < int'(n_act));
  end

  ewpf_exp_unit u_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (iss_v_q),
    .zero_i   (iss_z_q),
    .dist_i   (dist_q),
    .alpha_i  (rd_a_q),
    .weight_i (rd_w_q),
    .vld_o    (term_vld),
    .term_o   (term)
  );

  always_comb begin
    ring_ctrl.shift = term_vld || emit_go;
    ring_ctrl.add   = term_vld;
    ring_ctrl.clr   = emit_go;
    pass_ctrl.shift = ring_ctrl.shift;
    pass_ctrl.add   = 1'b0;
    pass_ctrl.clr   = 1'b0;
  end

  for (genvar j = 0; j < NUM_ALPHA; j++) begin : g_ring
    if (j == NUM_ALPHA - 1) begin : g_tail
      ewpf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ring_ctrl),
        .prev_i (sums[0]),
        .term_i (term),
        .sum_o  (sums[j])
      );
    end else begin : g_body
      ewpf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (pass_ctrl),
        .prev_i (sums[j+1]),
        .term_i (term),
        .sum_o  (sums[j])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go && emit_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go && emit_out) begin
      out_idx_q  <= 4'(cnt_q);
      out_val_q  <= sums[0];
      out_last_q <= (int'(cnt_q) + 1 == int'(n_act));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign feature_index_o = out_idx_q;
  assign feature_value_o = out_val_q;
  assign last_feature_o  = out_last_q;

endmodule

// ===== tb/tb_exp_weighted_pair_feature_accumulator.sv =====
// testbench for exp_weighted_pair_feature_accumulator: queue-fed driver, clocked monitor,
// bit-accurate fixed point predictor of the feature sums; depends on ewpf_pkg and the rtl
`timescale 1ns / 100ps

module tb_exp_weighted_pair_feature_accumulator import ewpf_pkg::*;;

  localparam longint LogE = 64'sd1549082005;
  localparam longint unsigned C1 = 64'd746848487;
  localparam longint unsigned C2 = 64'd242852024;
  localparam longint unsigned C3 = 64'd83908186;
  localparam longint unsigned EMax = (64'd1 << 28) - 1;
  localparam longint AccHi = (64'sd1 <<< 47) - 1;
  localparam longint AccLo = -(64'sd1 <<< 47);

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] dist_val;
    logic [2:0]  ntype;
    logic [3:0]  cidx;
    logic [15:0] alpha;
    logic [15:0] weight;
  } txn_t;

  typedef struct {
    logic [3:0]  idx;
    logic [47:0] value;
    logic        last;
  } feat_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] mode;
  logic signed [15:0] distance, alpha_coef, weight_coef;
  logic [2:0] neighbor_type;
  logic [3:0] coef_index;
  logic out_valid, out_ready;
  logic [3:0] feature_index;
  logic signed [47:0] feature_value;
  logic last_feature;

  txn_t  pending_q[$];
  feat_t feature_q[$];
  logic signed [15:0] alpha_tbl[128];
  logic signed [15:0] weight_tbl[128];
  longint sums[16];
  logic [4:0] num_alpha_reg;
  int send_idle, recv_idle;
  bit failed;
  bit taken;

  exp_weighted_pair_feature_accumulator u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .mode_i(mode),
    .distance_i(distance), .neighbor_type_i(neighbor_type), .coef_index_i(coef_index),
    .alpha_coef_i(alpha_coef), .weight_coef_i(weight_coef),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .feature_index_o(feature_index), .feature_value_o(feature_value),
    .last_feature_o(last_feature)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned exp_fixed(longint x);
    longint t, k;
    longint unsigned g, p;
    t = (x * LogE) >>> 36;
    k = t >>> 20;
    g = 64'(t - (k <<< 20)) << 10;
    p = C3;
    p = C2 + ((p * g) >> 30);
    p = C1 + ((p * g) >> 30);
    p = (64'd1 << 30) + ((p * g) >> 30);
    if (k >= 12) return EMax;
    if (14 - k >= 40) return 0;
    p = p >> (14 - k);
    return (p > EMax) ? EMax : p;
  endfunction

  function automatic int active_features();
    int n;
    n = num_alpha_reg;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic void accumulate(txn_t tr);
    int n, a;
    longint d, e, w, term, s;
    feat_t f;
    n = active_features();
    d = longint'(signed'(tr.dist_val));
    if (tr.mode == ModeLoad) begin
      a = tr.ntype * 16 + tr.cidx;
      alpha_tbl[a] = tr.alpha;
      weight_tbl[a] = tr.weight;
      return;
    end
    if (tr.mode == ModeAdd || tr.mode == ModeAddEmit) begin
      for (int i = 0; i < n; i++) begin
        a = tr.ntype * 16 + i;
        e = longint'(exp_fixed(longint'(alpha_tbl[a]) * d));
        w = longint'(weight_tbl[a]);
        term = (d * e * w) >>> 26;
        s = sums[i] + term;
        if (s > AccHi) s = AccHi;
        if (s < AccLo) s = AccLo;
        sums[i] = s;
      end
    end
    if (tr.mode == ModeAdd) return;
    for (int i = 0; i < n; i++) begin
      f.idx = i[3:0];
      f.value = sums[i][47:0];
      f.last = (i + 1 == n);
      feature_q.push_back(f);
    end
    for (int i = 0; i < 16; i++) sums[i] = 0;
  endfunction

  // acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      taken = 1'b1;
      accumulate('{mode, distance, neighbor_type, coef_index, alpha_coef, weight_coef});
    end
  end

  // driver
  always @(negedge clk) begin
    txn_t tr;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || taken) begin
        taken = 1'b0;
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          tr = pending_q.pop_front();
          in_valid <= 1'b1;
          mode <= tr.mode;
          distance <= tr.dist_val;
          neighbor_type <= tr.ntype;
          coef_index <= tr.cidx;
          alpha_coef <= tr.alpha;
          weight_coef <= tr.weight;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    feat_t f;
    if (rst_n && out_valid && out_ready) begin
      if (feature_q.size() == 0) begin
        $display("%0t: unexpected feature idx %0d value %0d", $time, feature_index,
                 feature_value);
        failed = 1'b1;
      end else begin
        f = feature_q.pop_front();
        if (feature_index !== f.idx) begin
          $display("%0t: index exp %0d got %0d", $time, f.idx, feature_index);
          failed = 1'b1;
        end
        if (feature_value !== f.value) begin
          $display("%0t: value exp %0d got %0d", $time, $signed(f.value), feature_value);
          failed = 1'b1;
        end
        if (last_feature !== f.last) begin
          $display("%0t: last exp %0d got %0d", $time, f.last, last_feature);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic push_txn(logic [1:0] m, logic [15:0] d, logic [2:0] ty, logic [3:0] ci,
                          logic [15:0] al, logic [15:0] wt);
    txn_t tr;
    tr = '{m, d, ty, ci, al, wt};
    pending_q.push_back(tr);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || feature_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_num_alpha(logic [4:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    num_alpha_reg = v;
  endtask

  function automatic logic [15:0] rand_dist();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($urandom_range(4000) - 2000);
  endfunction

  function automatic logic [15:0] rand_coef();
    if ($urandom_range(2) == 0) return 16'($urandom);
    return 16'($urandom_range(8192) - 4096);
  endfunction

  initial begin
    logic [4:0] cfg_vals[7];
    int r;
    logic [1:0] m;
    cfg_vals = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd0};
    cfg_vals[6] = 5'($urandom_range(31));
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    mode = '0;
    distance = '0;
    neighbor_type = '0;
    coef_index = '0;
    alpha_coef = '0;
    weight_coef = '0;
    failed = 1'b0;
    taken = 1'b0;
    send_idle = 14;
    recv_idle = 69;
    num_alpha_reg = 5'd16;
    for (int i = 0; i < 16; i++) sums[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill every table entry so no unwritten entry is ever read
    for (int t = 0; t < 8; t++)
      for (int i = 0; i < 16; i++)
        push_txn(ModeLoad, 16'h0, t[2:0], i[3:0], rand_coef(), rand_coef());
    drain();
    write_num_alpha(5'd16);

    // directed: extreme coefficients and distances, every mode
    push_txn(ModeEmit, 16'h0, 3'd0, 4'd0, 16'h0, 16'h0);
    push_txn(ModeLoad, 16'h0, 3'd0, 4'd0, 16'h7fff, 16'h7fff);
    push_txn(ModeLoad, 16'h0, 3'd0, 4'd1, 16'h8000, 16'h8000);
    push_txn(ModeLoad, 16'h0, 3'd7, 4'd15, 16'h8000, 16'h7fff);
    push_txn(ModeLoad, 16'h0, 3'd7, 4'd14, 16'h0000, 16'hffff);
    push_txn(ModeAdd, 16'h7fff, 3'd0, 4'd15, 16'hffff, 16'hffff);
    push_txn(ModeAdd, 16'h8000, 3'd0, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAddEmit, 16'h0000, 3'd7, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAdd, 16'hffff, 3'd7, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAdd, 16'h0001, 3'd7, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAddEmit, 16'h8000, 3'd7, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAddEmit, 16'h7fff, 3'd0, 4'd0, 16'h0, 16'h0);
    push_txn(ModeEmit, 16'h7fff, 3'd0, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAdd, 16'h4000, 3'd0, 4'd0, 16'h0, 16'h0);
    push_txn(ModeAddEmit, 16'hc000, 3'd0, 4'd0, 16'h0, 16'h0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 3) begin
        send_idle = 14;
        recv_idle = 69;
      end else if (ph < 5) begin
        send_idle = 69;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_num_alpha(cfg_vals[ph]);
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(99);
        if (r < 8) m = ModeLoad;
        else if (r < 70) m = ModeAdd;
        else if (r < 88) m = ModeAddEmit;
        else m = ModeEmit;
        push_txn(m, rand_dist(), 3'($urandom), 4'($urandom), rand_coef(), rand_coef());
      end
      push_txn(ModeEmit, 16'h0, 3'd0, 4'd0, 16'h0, 16'h0);
      drain();
    end

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
